>>> sv/assert_macros.svh
// Assertion helpers shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define MST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent/consequent form, same clock and reset gating.
`define MST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/mst_pkg.sv
package mst_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ID_W       = 8;
    localparam int TICK_W     = 32;
    localparam int HND_W      = 8;

    localparam logic [ID_W-1:0] ID_NONE = 8'hFF;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_SERVICE = 3'd1,
        MODE_CREATE  = 3'd2,
        MODE_CONFIG  = 3'd3,
        MODE_DELETE  = 3'd4,
        MODE_START   = 3'd5,
        MODE_STOP    = 3'd6,
        MODE_READ    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_STOPPED = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TY_UNDEF   = 2'd0,
        TY_ONESHOT = 2'd1,
        TY_RELOAD  = 2'd2,
        TY_KEEP    = 2'd3
    } t_ttype;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_CREATE = 2'd2,
        KIND_STATE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_status             status;
        t_ttype              ttype;
        logic [TICK_W-1:0]   period;
        logic [TICK_W-1:0]   deadline;
        logic [HND_W-1:0]    handler;
    } t_slot_entry;

    typedef struct packed {
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_addr;
        t_slot_entry         wr_entry;
    } t_store_req;

endpackage

>>> sv/mst_ram.sv
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mst_slot_store.sv
`include "assert_macros.svh"

module mst_slot_store
    import mst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_req  i_req,
    output t_slot_entry o_rd_entry
);

    localparam int CTRL_W = $bits(t_status) + $bits(t_ttype);
    localparam int DATA_W = 2 * TICK_W + HND_W;

    logic [CTRL_W-1:0]     w_ctrl_wdata;
    logic [CTRL_W-1:0]     w_ctrl_rdata;
    logic [DATA_W-1:0]     w_data_wdata;
    logic [DATA_W-1:0]     w_data_rdata;
    logic [SLOT_COUNT-1:0] r_vld;
    logic                  r_rd_vld;

    assign w_ctrl_wdata = {i_req.wr_entry.status, i_req.wr_entry.ttype};
    assign w_data_wdata = {i_req.wr_entry.period, i_req.wr_entry.deadline,
                           i_req.wr_entry.handler};

    // status and type
    mst_ram #(.WIDTH(CTRL_W), .DEPTH(SLOT_COUNT)) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (w_ctrl_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (w_ctrl_rdata)
    );

    // period, deadline, handler
    mst_ram #(.WIDTH(DATA_W), .DEPTH(SLOT_COUNT)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (w_data_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (w_data_rdata)
    );

    // unwritten slots read as empty / undefined type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_vld <= r_vld[i_req.rd_addr];
        end
    end

    always_comb begin
        o_rd_entry.status   = r_rd_vld ? t_status'(w_ctrl_rdata[CTRL_W-1 -: 2]) : ST_EMPTY;
        o_rd_entry.ttype    = r_rd_vld ? t_ttype'(w_ctrl_rdata[1:0]) : TY_UNDEF;
        o_rd_entry.period   = w_data_rdata[DATA_W-1 -: TICK_W];
        o_rd_entry.deadline = w_data_rdata[HND_W +: TICK_W];
        o_rd_entry.handler  = w_data_rdata[HND_W-1:0];
    end

    // the controller never reads and writes one slot in the same cycle
    `MST_ASSERT(a_no_rw_same_slot, !(i_req.rd_en && i_req.wr_en && (i_req.rd_addr == i_req.wr_addr)), "read and write hit the same slot")

endmodule

>>> sv/multi_slot_software_timer.sv
// Timer table with SLOT_COUNT slots held in a slot memory (status/type
// plus period/deadline/handler) beside a 32-bit tick counter. Each request
// carries one mode (tick, service, create, configure, delete, start, stop,
// read state) and yields exactly one result, kind "nothing" included.
// For every request the accept edge issues the slot read and the next
// cycle does the update, the write-back and loads the result register;
// create may instead read on. Create walks the slots one memory read per
// cycle looking for the first empty one, up to the last slot. One request is
// in flight at a time; a new request is taken while the previous result
// is being drained from the output register. Service steps only run while
// the enabled register is set; ids at or above SLOT_COUNT are ignored,
// except that a read of one answers with status error. Deadlines are
// compared unsigned with no wrap handling. The enabled register may only
// be written while the block is idle.
`include "assert_macros.svh"

module multi_slot_software_timer
    import mst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_enabled,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_mode,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [1:0]        i_timer_type,
    input  logic [TICK_W-1:0] i_period,
    input  logic [HND_W-1:0]  i_handler_tag,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_result_kind,
    output logic [ID_W-1:0]   o_slot_id,
    output logic [HND_W-1:0]  o_fired_handler,
    output logic [1:0]        o_slot_status,
    output logic              o_accepted,
    output logic [TICK_W-1:0] o_tick_now
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    t_state            r_state, n_state;
    logic              r_enabled;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [SLOT_W-1:0] r_scan, n_scan;
    logic [SLOT_W-1:0] r_addr, n_addr;

    // captured request
    t_mode             r_mode;
    logic [ID_W-1:0]   r_id;
    t_ttype            r_type;
    logic [TICK_W-1:0] r_period;
    logic [HND_W-1:0]  r_handler;

    // result register
    logic              r_out_valid;
    t_kind             r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_slot, n_out_slot;
    logic [HND_W-1:0]  r_out_handler, n_out_handler;
    t_status           r_out_status, n_out_status;
    logic              r_out_acc, n_out_acc;

    logic              w_in_accept;
    logic              w_done;
    logic              w_id_ok;
    t_mode             w_in_mode;
    t_store_req        w_req;
    t_slot_entry       w_rd;
    t_slot_entry       w_upd;

    assign o_cfg_ready = 1'b1;

    // result register is free next cycle if empty now or drained now
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_in_mode   = t_mode'(i_mode);
    assign w_id_ok     = (9'(r_id) < 9'(SLOT_COUNT));

    mst_slot_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rd_entry (w_rd)
    );

    always_comb begin
        n_state       = r_state;
        n_tick        = r_tick;
        n_scan        = r_scan;
        n_addr        = r_addr;
        w_done        = 1'b0;
        w_upd         = w_rd;
        w_req.rd_en   = 1'b0;
        w_req.rd_addr = r_addr;
        w_req.wr_en   = 1'b0;
        w_req.wr_addr = r_addr;
        n_out_kind    = KIND_NONE;
        n_out_slot    = '0;
        n_out_handler = '0;
        n_out_status  = ST_EMPTY;
        n_out_acc     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state     = S_EXEC;
                    w_req.rd_en = 1'b1;
                    case (w_in_mode)
                        MODE_SERVICE: w_req.rd_addr = r_scan;
                        MODE_CREATE:  w_req.rd_addr = '0;
                        default:      w_req.rd_addr = i_timer_id[SLOT_W-1:0];
                    endcase
                    n_addr = w_req.rd_addr;
                end
            end
            S_EXEC: begin
                w_done = 1'b1;
                case (r_mode)
                    MODE_TICK: begin
                        n_tick = r_tick + 1'b1;
                    end
                    MODE_SERVICE: begin
                        if (r_enabled) begin
                            n_scan = (r_scan == LAST_SLOT) ? '0 : r_scan + 1'b1;
                            if (w_rd.status == ST_RUNNING && r_tick >= w_rd.deadline) begin
                                // handler zero flags error first, type rule then applies
                                if (w_rd.handler == '0) begin
                                    w_upd.status = ST_ERROR;
                                end
                                case (w_rd.ttype)
                                    TY_ONESHOT: w_upd.status = ST_STOPPED;
                                    TY_RELOAD:  w_upd.deadline = w_rd.deadline + w_rd.period;
                                    default:    w_upd.status = ST_ERROR;
                                endcase
                                w_req.wr_en   = 1'b1;
                                n_out_kind    = KIND_EXPIRY;
                                n_out_slot    = ID_W'(r_addr);
                                n_out_handler = w_rd.handler;
                                n_out_status  = w_upd.status;
                            end
                        end
                    end
                    MODE_CREATE: begin
                        n_out_kind = KIND_CREATE;
                        n_out_slot = ID_NONE;
                        if (w_rd.status == ST_EMPTY) begin
                            if (r_handler != '0 && r_period != '0 && r_type != TY_KEEP) begin
                                w_upd.status   = ST_RUNNING;
                                w_upd.ttype    = r_type;
                                w_upd.period   = r_period;
                                w_upd.deadline = r_tick + r_period;
                                w_upd.handler  = r_handler;
                                w_req.wr_en    = 1'b1;
                                n_out_slot     = ID_W'(r_addr);
                                n_out_status   = ST_RUNNING;
                                n_out_acc      = 1'b1;
                            end
                        end else if (r_addr != LAST_SLOT) begin
                            // keep walking
                            w_done        = 1'b0;
                            n_addr        = r_addr + 1'b1;
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = n_addr;
                        end
                    end
                    MODE_CONFIG: begin
                        if (w_id_ok && w_rd.status != ST_EMPTY) begin
                            if (r_handler != '0) begin
                                w_upd.handler = r_handler;
                            end
                            if (r_type != TY_KEEP) begin
                                w_upd.ttype = r_type;
                            end
                            if (r_period != '0) begin
                                w_upd.period = r_period;
                            end
                            w_req.wr_en = 1'b1;
                        end
                    end
                    MODE_DELETE: begin
                        if (w_id_ok) begin
                            w_upd.status = ST_EMPTY;
                            w_req.wr_en  = 1'b1;
                        end
                    end
                    MODE_START: begin
                        if (w_id_ok && w_rd.status != ST_EMPTY) begin
                            w_upd.deadline = r_tick + w_rd.period;
                            w_upd.status   = ST_RUNNING;
                            w_req.wr_en    = 1'b1;
                        end
                    end
                    MODE_STOP: begin
                        if (w_id_ok && w_rd.status != ST_EMPTY) begin
                            w_upd.status = ST_STOPPED;
                            w_req.wr_en  = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        n_out_kind   = KIND_STATE;
                        n_out_slot   = r_id;
                        n_out_status = w_id_ok ? w_rd.status : ST_ERROR;
                    end
                    default: begin
                        n_out_kind = KIND_NONE;
                    end
                endcase
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_req.wr_entry = w_upd;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_tick      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_scan  <= n_scan;
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_enabled;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (w_in_accept) begin
            r_mode    <= w_in_mode;
            r_id      <= i_timer_id;
            r_type    <= t_ttype'(i_timer_type);
            r_period  <= i_period;
            r_handler <= i_handler_tag;
        end
        if (w_done) begin
            r_out_kind    <= n_out_kind;
            r_out_slot    <= n_out_slot;
            r_out_handler <= n_out_handler;
            r_out_status  <= n_out_status;
            r_out_acc     <= n_out_acc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_slot_id       = r_out_slot;
    assign o_fired_handler = r_out_handler;
    assign o_slot_status   = r_out_status;
    assign o_accepted      = r_out_acc;
    assign o_tick_now      = r_tick;

    `MST_ASSERT(a_exec_out_free, !((r_state == S_EXEC) && r_out_valid), "result register busy while executing")
    `MST_ASSERT_IMP(a_out_from_exec, $rose(r_out_valid), $past(r_state == S_EXEC), "result loaded outside execute")
    `MST_ASSERT_IMP(a_tick_only_on_tick, $past(i_rst_n) && (r_tick != $past(r_tick)), $past((r_state == S_EXEC) && (r_mode == MODE_TICK)), "tick counter moved without a tick request")

endmodule
